// ----- src/gre_pkg.sv -----
// ----------------------------------------------------------------------------
// gre_pkg
// Shared constants and controller/datapath handshake types for the glyph
// run-length expander.
// ----------------------------------------------------------------------------
package gre_pkg;

  localparam int PIXELS_PER_RESULT_DEF = 4;
  localparam int MAX_RESULTS           = 64;

  localparam logic [7:0] ESCAPE_CODE = 8'h41;
  localparam logic [7:0] RUN_BIAS    = 8'h40;

  localparam logic FORMAT_ESCAPE = 1'b0;
  localparam logic FORMAT_BIASED = 1'b1;

  typedef struct packed {
    logic accept;
    logic emit;
  } gre_cmd_t;

  typedef struct packed {
    logic run_pending;
    logic out_free;
    logic last_chunk;
  } gre_sts_t;

endpackage

// ----- src/gre_ctrl.sv -----
// ----------------------------------------------------------------------------
// gre_ctrl
// Controller: takes one byte when idle, then emits its run chunk by chunk.
// ----------------------------------------------------------------------------
module gre_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gre_pkg::gre_sts_t sts,
  output gre_pkg::gre_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.emit   = 1'b0;
    in_stall   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && sts.run_pending) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
        if (sts.out_free && sts.last_chunk) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/gre_dpath.sv -----
// ----------------------------------------------------------------------------
// gre_dpath
// Datapath: byte decode, glyph state, run counter and output register.
// ----------------------------------------------------------------------------
module gre_dpath #(
  parameter int PIXELS_PER_RESULT = gre_pkg::PIXELS_PER_RESULT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_data,
  input  logic [7:0]        in_code_byte,
  input  logic              in_glyph_start,
  input  logic [15:0]       in_glyph_pixels,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_pixel_level,
  output logic [2:0]        out_repeat_count,
  output logic              out_glyph_done,
  output logic              out_run_end,
  input  gre_pkg::gre_cmd_t cmd,
  output gre_pkg::gre_sts_t sts
);

  localparam int RUN_CAP = gre_pkg::MAX_RESULTS * PIXELS_PER_RESULT;

  logic        fmt_r;
  logic        awaiting_r, awaiting_nxt;
  logic [7:0]  last_level_r, last_level_nxt;
  logic [15:0] pixels_left_r, pixels_left_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_level_r;
  logic [2:0]  out_count_r;
  logic        out_done_r;
  logic        out_end_r;

  logic [15:0] pl_eff;
  logic        aw_eff;
  logic [7:0]  ll_eff;
  logic [7:0]  run_len;
  logic [7:0]  clip_pix;
  logic [7:0]  clip_len;
  logic [7:0]  chunk;

  // decode of the byte on the input
  always_comb begin
    pl_eff       = in_glyph_start ? in_glyph_pixels : pixels_left_r;
    aw_eff       = in_glyph_start ? 1'b0 : awaiting_r;
    ll_eff       = in_glyph_start ? 8'h00 : last_level_r;
    awaiting_nxt = aw_eff;
    last_level_nxt = ll_eff;
    run_len      = 8'h00;
    if (pl_eff != 16'h0000) begin
      if (aw_eff) begin
        awaiting_nxt = 1'b0;
        run_len      = in_code_byte;
      end else if (fmt_r == gre_pkg::FORMAT_ESCAPE &&
                   in_code_byte == gre_pkg::ESCAPE_CODE) begin
        awaiting_nxt = 1'b1;
      end else if (fmt_r == gre_pkg::FORMAT_BIASED &&
                   in_code_byte >= gre_pkg::ESCAPE_CODE) begin
        run_len = in_code_byte - gre_pkg::RUN_BIAS;
      end else begin
        last_level_nxt = in_code_byte;
        run_len        = 8'h01;
      end
    end
    clip_pix = (pl_eff < {8'h00, run_len}) ? pl_eff[7:0] : run_len;
    clip_len = ({2'b00, clip_pix} > 10'(RUN_CAP)) ? 8'(RUN_CAP) : clip_pix;
  end

  assign chunk = (rem_r < 8'(PIXELS_PER_RESULT)) ? rem_r : 8'(PIXELS_PER_RESULT);

  always_comb begin
    pixels_left_nxt = pixels_left_r;
    rem_nxt         = rem_r;
    if (cmd.accept) begin
      pixels_left_nxt = pl_eff;
      rem_nxt         = clip_len;
    end else if (cmd.emit) begin
      pixels_left_nxt = pixels_left_r - {8'h00, chunk};
      rem_nxt         = rem_r - chunk;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  assign sts.run_pending = clip_len != 8'h00;
  assign sts.out_free    = !out_valid_r || !out_stall;
  assign sts.last_chunk  = rem_r <= 8'(PIXELS_PER_RESULT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r         <= gre_pkg::FORMAT_BIASED;
      awaiting_r    <= 1'b0;
      last_level_r  <= 8'h00;
      pixels_left_r <= 16'h0000;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        fmt_r <= cfg_data;
      end
      if (cmd.accept) begin
        awaiting_r   <= awaiting_nxt;
        last_level_r <= last_level_nxt;
      end
      pixels_left_r <= pixels_left_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (cmd.emit) begin
      out_level_r <= last_level_r;
      out_count_r <= chunk[2:0];
      out_done_r  <= pixels_left_r == {8'h00, chunk};
      out_end_r   <= rem_r == chunk;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_level  = out_level_r;
  assign out_repeat_count = out_count_r;
  assign out_glyph_done   = out_done_r;
  assign out_run_end      = out_end_r;

endmodule

// ----- src/glyph_run_length_expander_core.sv -----
// ----------------------------------------------------------------------------
// glyph_run_length_expander_core
// Expands compressed glyph bytes into pixel levels with repeat counts.
// ----------------------------------------------------------------------------
// One byte is taken at a time. A byte that yields no result (escape, zero
// run, finished glyph) leaves the controller idle; a byte that yields N
// results is taken first and its N results follow, N = ceil(run / 4) for
// the default PIXELS_PER_RESULT, so a literal yields one result and the
// longest run 64. The run counter in the datapath emits one result per cycle
// through the output register while out_stall does not hold it. cfg_data selects the format
// (0 escape plus length byte, 1 biased run bytes) and is always ready.
module glyph_run_length_expander_core #(
  parameter int PIXELS_PER_RESULT = gre_pkg::PIXELS_PER_RESULT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_code_byte,
  input  logic        in_glyph_start,
  input  logic [15:0] in_glyph_pixels,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_level,
  output logic [2:0]  out_repeat_count,
  output logic        out_glyph_done,
  output logic        out_run_end
);

  gre_pkg::gre_cmd_t cmd;
  gre_pkg::gre_sts_t sts;

  assign cfg_ready = 1'b1;

  gre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gre_dpath #(
    .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .in_code_byte     (in_code_byte),
    .in_glyph_start   (in_glyph_start),
    .in_glyph_pixels  (in_glyph_pixels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_level  (out_pixel_level),
    .out_repeat_count (out_repeat_count),
    .out_glyph_done   (out_glyph_done),
    .out_run_end      (out_run_end),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

// ----- src/gre_checker.sv -----
// ----------------------------------------------------------------------------
// gre_checker
// Port-level checks for the glyph run-length expander.
// ----------------------------------------------------------------------------
module gre_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_pixel_level,
  input logic [2:0] out_repeat_count,
  input logic       out_glyph_done,
  input logic       out_run_end
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_level) &&
    $stable(out_repeat_count) && $stable(out_run_end))
    else $error("stalled output item changed");

  // glyph end always closes the run
  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_glyph_done |-> out_run_end)
    else $error("glyph done without run end");

  // a new byte is only taken after its predecessor's last item
  a_accept_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && out_valid |-> out_run_end)
    else $error("byte accepted while a run is still open");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind glyph_run_length_expander_core gre_checker u_gre_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pixel_level  (out_pixel_level),
  .out_repeat_count (out_repeat_count),
  .out_glyph_done   (out_glyph_done),
  .out_run_end      (out_run_end)
);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for glyph_run_length_expander_core. A queue of code
// bytes feeds a clocked driver; each accepted item is expanded by a local
// decoder into the pixel runs it owes, and a clocked monitor checks every
// result against the oldest of them. Both formats, escapes, clipping, random
// gaps and stalls, and one long output hold-off are covered.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PIXELS_PER_ITEM = gre_pkg::PIXELS_PER_RESULT_DEF;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int HOLD_CYCLES     = 300;

  typedef struct packed {
    logic [7:0]  code;
    logic        start;
    logic [15:0] npix;
  } code_item_t;

  typedef struct packed {
    logic [7:0] level;
    logic [2:0] count;
    logic       done;
    logic       last;
  } pixel_run_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_code_byte = '0;
  logic        in_glyph_start = 1'b0;
  logic [15:0] in_glyph_pixels = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_pixel_level;
  logic [2:0]  out_repeat_count;
  logic        out_glyph_done;
  logic        out_run_end;

  code_item_t code_bytes_todo[$];
  pixel_run_t pixel_runs_due[$];

  // local copy of the decoder state
  logic        fmt_sel = gre_pkg::FORMAT_BIASED;
  logic        escape_seen = 1'b0;
  logic [7:0]  prev_level = '0;
  logic [15:0] pixels_owed = '0;

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_go = 1'b0;
  logic        with_gaps = 1'b1;

  glyph_run_length_expander_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_code_byte     (in_code_byte),
    .in_glyph_start   (in_glyph_start),
    .in_glyph_pixels  (in_glyph_pixels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_level  (out_pixel_level),
    .out_repeat_count (out_repeat_count),
    .out_glyph_done   (out_glyph_done),
    .out_run_end      (out_run_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void queue_pixels(logic [7:0] level, int unsigned len);
    int unsigned left;
    int unsigned chunk;
    pixel_run_t run;
    left = len;
    if (left > pixels_owed) left = pixels_owed;
    if (left > gre_pkg::MAX_RESULTS * PIXELS_PER_ITEM)
      left = gre_pkg::MAX_RESULTS * PIXELS_PER_ITEM;
    while (left > 0) begin
      chunk = (left < PIXELS_PER_ITEM) ? left : PIXELS_PER_ITEM;
      left -= chunk;
      pixels_owed = pixels_owed - 16'(chunk);
      run.level = level;
      run.count = 3'(chunk);
      run.done = (pixels_owed == 0);
      run.last = (left == 0);
      pixel_runs_due.push_back(run);
    end
  endfunction

  function automatic void expand_byte(logic [7:0] code, logic start, logic [15:0] npix);
    if (start) begin
      pixels_owed = npix;
      prev_level = '0;
      escape_seen = 1'b0;
    end
    if (pixels_owed == 0) return;
    if (escape_seen) begin
      escape_seen = 1'b0;
      queue_pixels(prev_level, int'(code));
      return;
    end
    if (fmt_sel == gre_pkg::FORMAT_ESCAPE) begin
      if (code == gre_pkg::ESCAPE_CODE) begin
        escape_seen = 1'b1;
        return;
      end
    end else if (code >= gre_pkg::ESCAPE_CODE) begin
      queue_pixels(prev_level, int'(code) - int'(gre_pkg::RUN_BIAS));
      return;
    end
    prev_level = code;
    queue_pixels(code, 1);
  endfunction

  // driver
  always @(posedge clk) begin
    logic next_valid;
    code_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        expand_byte(in_code_byte, in_glyph_start, in_glyph_pixels);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (code_bytes_todo.size() != 0) begin
          nxt = code_bytes_todo.pop_front();
          in_code_byte <= nxt.code;
          in_glyph_start <= nxt.start;
          in_glyph_pixels <= nxt.npix;
          next_valid = 1'b1;
          gap_left = with_gaps ? $urandom_range(0, 6) : 0;
        end
      end
      in_valid <= next_valid;
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_run_t want;
    pixel_run_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_pixel_level, out_repeat_count, out_glyph_done, out_run_end};
        if (pixel_runs_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item level=%0d count=%0d done=%0b end=%0b", $time,
                   got.level, got.count, got.done, got.last);
        end else begin
          want = pixel_runs_due.pop_front();
          if (got !== want) begin
            mismatches++;
            $display({"%0t: exp level=%0d count=%0d done=%0b end=%0b, ",
                      "got level=%0d count=%0d done=%0b end=%0b"},
                     $time, want.level, want.count, want.done, want.last,
                     got.level, got.count, got.done, got.last);
          end
        end
        stall_left = with_gaps ? $urandom_range(0, 6) : 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0) || (hold_left != 0);
    end
  end

  // long output hold-off
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[glyph_run_length_expander_core] ERROR");
      $finish;
    end
  end

  task automatic push_item(logic [7:0] code, logic start = 1'b0, logic [15:0] npix = '0);
    code_item_t item;
    item.code = code;
    item.start = start;
    item.npix = npix;
    code_bytes_todo.push_back(item);
  endtask

  task automatic drain();
    while (code_bytes_todo.size() != 0 || in_valid || pixel_runs_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_format(logic value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    fmt_sel = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(logic fmt, int unsigned n);
    int unsigned sent;
    logic [15:0] npix;
    logic start;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 7) == 0) begin
        // noise
        push_item(8'($urandom), $urandom_range(0, 3) == 0, 16'($urandom));
        sent++;
      end else begin
        npix = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 120));
        start = 1'b1;
        repeat ($urandom_range(1, 12)) begin
          if (fmt == gre_pkg::FORMAT_BIASED) begin
            case ($urandom_range(0, 3))
              0: push_item(8'($urandom_range(8'h41, 8'h4c)), start, npix);
              1: push_item(8'($urandom_range(8'h41, 8'hff)), start, npix);
              default: push_item(8'($urandom_range(0, 8'h40)), start, npix);
            endcase
          end else if ($urandom_range(0, 3) == 0) begin
            push_item(gre_pkg::ESCAPE_CODE, start, npix);
            push_item(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12)),
                      1'b0, 16'($urandom));
            sent++;
          end else begin
            push_item(8'($urandom), start, npix);
          end
          start = 1'b0;
          npix = 16'($urandom);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // biased runs, reset format
    push_item(8'h00);
    push_item(8'h10, 1'b1, 16'd0);
    push_item(8'hff, 1'b1, 16'hffff);
    push_item(8'h40);
    push_item(8'h00);
    push_item(8'h41);
    push_item(8'h7f, 1'b1, 16'd5);
    push_item(8'h22);
    push_item(8'h3a, 1'b1, 16'd1);
    drain();

    // escape plus length byte
    set_format(gre_pkg::FORMAT_ESCAPE);
    push_item(8'h80, 1'b1, 16'd300);
    push_item(gre_pkg::ESCAPE_CODE);
    push_item(8'h00);
    push_item(gre_pkg::ESCAPE_CODE);
    push_item(gre_pkg::ESCAPE_CODE);
    push_item(8'hff);
    push_item(gre_pkg::ESCAPE_CODE);
    push_item(8'hff);
    push_item(gre_pkg::ESCAPE_CODE, 1'b1, 16'd10);
    push_item(8'h09);
    push_item(gre_pkg::ESCAPE_CODE);
    push_item(8'h07, 1'b1, 16'd3);
    push_item(gre_pkg::ESCAPE_CODE, 1'b1, 16'd50);
    drain();

    // pending escape survives the format change
    set_format(gre_pkg::FORMAT_BIASED);
    push_item(8'h02);
    push_item(8'h41);
    drain();

    with_gaps = 1'b1;
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    random_phase(gre_pkg::FORMAT_BIASED, 30);
    drain();

    set_format(gre_pkg::FORMAT_ESCAPE);
    with_gaps = 1'b0;
    random_phase(gre_pkg::FORMAT_ESCAPE, 30);
    drain();

    set_format(gre_pkg::FORMAT_BIASED);
    with_gaps = 1'b1;
    random_phase(gre_pkg::FORMAT_BIASED, 30);
    drain();

    set_format(gre_pkg::FORMAT_ESCAPE);
    random_phase(gre_pkg::FORMAT_ESCAPE, 30);
    drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pixel_runs_due.size() == 0) begin
      $display("[glyph_run_length_expander_core] OK");
    end else begin
      $display("[glyph_run_length_expander_core] ERROR");
    end
    $finish;
  end

endmodule
